### src/armr_pkg.sv
// ----------------------------------------------------------------------------
// armr_pkg: shared types and constants of the resampling ring
// Holds the register map, reset values, the source rate and the types that
// travel between the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package armr_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_OUT_RATE     = 2'd0;
   localparam logic [1:0] CSR_FRAME_LEN    = 2'd1;
   localparam logic [1:0] CSR_POKEY_ENABLE = 2'd2;

   localparam logic [16:0] OUT_RATE_RESET     = 17'd44100;
   localparam logic [11:0] FRAME_LEN_RESET    = 12'd735;
   localparam logic        POKEY_ENABLE_RESET = 1'b0;

   // source sample rate in Hz, taken off the accumulator per copy
   localparam logic [17:0] SRC_RATE = 18'd31440;

   // command queue depth between front and back end
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [16:0] out_rate;
      logic [11:0] frame_len;
      logic        pokey_enable;
   } cfg_type;

   typedef struct packed {
      logic       is_read;
      logic       frame_start;
      logic [7:0] sample;
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE
   } state_type;

endpackage

### src/armr_ram.sv
// ----------------------------------------------------------------------------
// armr_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered (read-first when
// both ports hit the same address).
// ----------------------------------------------------------------------------
module armr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/armr_front.sv
// ----------------------------------------------------------------------------
// armr_front: request intake and classification
// Accepts request beats, forms the mixed sample and hands one command per
// beat to the queue. Holds off while the ring is being cleared.
// ----------------------------------------------------------------------------
module armr_front (
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,
   input  logic [1:0]           req_tuser,
   input  logic                 pokey_enable,
   input  logic                 clear_busy,
   input  logic                 push_ready,
   output logic                 push,
   output armr_pkg::op_type     push_op
);

   logic [7:0] tia_sample;
   logic [7:0] pokey_sample;
   logic [8:0] mix_sum;

   assign tia_sample   = req_tdata[7:0];
   assign pokey_sample = req_tdata[15:8];

   // nine-bit sum keeps the carry, then halve
   assign mix_sum = {1'b0, tia_sample} + {1'b0, pokey_sample};

   always_comb begin
      push_op.is_read     = req_tuser[0];
      push_op.frame_start = req_tuser[1];
      push_op.sample      = pokey_enable ? mix_sum[8:1] : tia_sample;
   end

   assign req_tready = push_ready && !clear_busy;
   assign push       = req_tvalid && req_tready;

endmodule

### src/armr_queue.sv
// ----------------------------------------------------------------------------
// armr_queue: short command queue
// Decouples the front end from the back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module armr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  armr_pkg::op_type push_op,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output armr_pkg::op_type pop_op
);

   localparam int unsigned PW = $clog2(armr_pkg::QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(armr_pkg::QUEUE_DEPTH + 1);

   armr_pkg::op_type entry_ff [armr_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign push_ready = (count_ff != CW'(armr_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(armr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(armr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

### src/armr_back.sv
// ----------------------------------------------------------------------------
// armr_back: ring execution engine
// Clears the ring after reset, runs the rate accumulator and writes held
// copies one per cycle, pops bytes for read commands into the result register.
// ----------------------------------------------------------------------------
module armr_back #(
   parameter int unsigned RING_DEPTH = 16384
) (
   input  logic             clock,
   input  logic             reset,
   input  armr_pkg::cfg_type cfg,
   input  logic             pop_valid,
   input  armr_pkg::op_type pop_op,
   output logic             pop,
   output logic             clear_busy,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata
);

   localparam int unsigned AW = $clog2(RING_DEPTH);

   armr_pkg::state_type state_ff, state_in;

   logic [17:0]   acc_ff, acc_in;
   logic [11:0]   cnt_ff, cnt_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] rp_ff, rp_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [7:0]    smp_ff, smp_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic          ram_re;
   logic [7:0]    ram_rdata;
   logic          copy_go;

   armr_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rp_ff),
      .rd_data (ram_rdata)
   );

   assign copy_go = (acc_ff >= armr_pkg::SRC_RATE) && (cnt_ff < cfg.frame_len);

   always_comb begin
      state_in   = state_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      clr_in     = clr_ff;
      smp_in     = smp_ff;
      rd_pend_in = 1'b0;
      pop        = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = wp_ff;
      ram_wdata  = smp_ff;
      ram_re     = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (rd_pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ram_rdata;
      end

      unique case (state_ff)
         armr_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            if (clr_ff == AW'(RING_DEPTH - 1)) begin
               state_in = armr_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         armr_pkg::ST_IDLE: begin
            if (pop_valid) begin
               if (pop_op.is_read) begin
                  // read-first RAM: fetch the byte and zero its slot together
                  if (!rsp_valid_ff && !rd_pend_ff) begin
                     pop        = 1'b1;
                     ram_re     = 1'b1;
                     ram_we     = 1'b1;
                     ram_waddr  = rp_ff;
                     ram_wdata  = '0;
                     rd_pend_in = 1'b1;
                     rp_in      = (rp_ff == AW'(RING_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
                  end
               end else begin
                  pop      = 1'b1;
                  smp_in   = pop_op.sample;
                  state_in = armr_pkg::ST_WRITE;
                  if (pop_op.frame_start) begin
                     acc_in = {1'b0, cfg.out_rate};
                     cnt_in = '0;
                  end else if (cnt_ff < cfg.frame_len) begin
                     acc_in = acc_ff + {1'b0, cfg.out_rate};
                  end
               end
            end
         end
         armr_pkg::ST_WRITE: begin
            if (copy_go) begin
               ram_we = 1'b1;
               wp_in  = (wp_ff == AW'(RING_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
               acc_in = acc_ff - armr_pkg::SRC_RATE;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = armr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = armr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= armr_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         clr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         clr_ff       <= clr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff      <= smp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign clear_busy = (state_ff == armr_pkg::ST_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### src/audio_resample_mix_ring.sv
// ----------------------------------------------------------------------------
// audio_resample_mix_ring: accumulator resampler feeding a byte ring
// Top level: configuration registers, front end, command queue, back end.
// ----------------------------------------------------------------------------
// A request beat either delivers one source sample (tuser bit 0 low) or pops
// one byte from the ring (tuser bit 0 high). A source sample, optionally
// averaged with the POKEY byte, is written into the ring as zero-order-hold
// copies: the rate accumulator gains out_rate per sample and loses 31440 per
// copy, and a frame stops taking copies after frame_len of them. A pop returns
// the oldest slot, zeroes it and advances; writes never check for a full ring.
// After reset all RING_DEPTH entries of the ring are swept to zero, one entry
// per cycle; no request beat is taken meanwhile (register writes still are).
// In the back end a pop reads its byte into the RAM output register and from
// there into the result register, and a further pop waits until that byte is
// taken. A source sample is handled as the accumulator update when it is
// popped, then one ring write per copy (at most three at a frame start and
// four otherwise while out_rate stays below four times 31440, more only if
// frame_len is raised mid-frame) and a closing check; copies share the single
// ring write port. A two-beat queue lets the request side keep accepting
// while the back end works or a result waits.
// ----------------------------------------------------------------------------
module audio_resample_mix_ring #(
   parameter int unsigned RING_DEPTH = 16384
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] tia_sample, [15:8] pokey_sample
   input  logic [1:0]  req_tuser,   // [0] req_type, [1] frame_start
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] read_data
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data
);

   armr_pkg::cfg_type cfg_ff, cfg_in;

   logic             clear_busy;
   logic             push;
   logic             push_ready;
   armr_pkg::op_type push_op;
   logic             pop;
   logic             pop_valid;
   armr_pkg::op_type pop_op;

   // registers take a write on every cycle; index three is dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            armr_pkg::CSR_OUT_RATE:     cfg_in.out_rate     = csr_data;
            armr_pkg::CSR_FRAME_LEN:    cfg_in.frame_len    = csr_data[11:0];
            armr_pkg::CSR_POKEY_ENABLE: cfg_in.pokey_enable = csr_data[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.out_rate     <= armr_pkg::OUT_RATE_RESET;
         cfg_ff.frame_len    <= armr_pkg::FRAME_LEN_RESET;
         cfg_ff.pokey_enable <= armr_pkg::POKEY_ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify the beat and form the mixed sample
   armr_front u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .pokey_enable (cfg_ff.pokey_enable),
      .clear_busy   (clear_busy),
      .push_ready   (push_ready),
      .push         (push),
      .push_op      (push_op)
   );

   // hold commands while the back end is busy
   armr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_op     (pop_op)
   );

   // advance the accumulator, write copies, pop bytes
   armr_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_op     (pop_op),
      .pop        (pop),
      .clear_busy (clear_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### tb/ring_byte_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_byte_checker: predicts and checks the popped bytes of the resampler
// Mirrors the register file, rate accumulator, frame quota and byte ring from
// the accepted beats, then compares every result beat with the oldest byte due.
// ----------------------------------------------------------------------------
module ring_byte_checker #(
   parameter int unsigned RING_DEPTH = 16384
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data,
   output int          mismatches,
   output int          bytes_pending
);

   localparam int unsigned REPORT_LIMIT = 10;

   armr_pkg::cfg_type cfg;
   logic [7:0]  ring_copy [RING_DEPTH];
   int unsigned wr_ptr;
   int unsigned rd_ptr;
   logic [17:0] rate_acc;
   logic [11:0] copies_in_frame;
   logic [7:0]  bytes_due [$];
   int          errors;

   always @(posedge clock) begin : model
      logic [8:0] mix_sum;
      logic [7:0] sample;
      logic [7:0] due;

      if (reset) begin
         cfg.out_rate     = armr_pkg::OUT_RATE_RESET;
         cfg.frame_len    = armr_pkg::FRAME_LEN_RESET;
         cfg.pokey_enable = armr_pkg::POKEY_ENABLE_RESET;
         for (int k = 0; k < RING_DEPTH; k++) ring_copy[k] = 8'h00;
         wr_ptr          = 0;
         rd_ptr          = 0;
         rate_acc        = '0;
         copies_in_frame = '0;
         bytes_due.delete();
         errors          = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               armr_pkg::CSR_OUT_RATE:     cfg.out_rate     = csr_data;
               armr_pkg::CSR_FRAME_LEN:    cfg.frame_len    = csr_data[11:0];
               armr_pkg::CSR_POKEY_ENABLE: cfg.pokey_enable = csr_data[0];
               default: ;
            endcase
         end

         // results first: a pop accepted on this edge cannot answer yet
         if (rsp_tvalid && rsp_tready) begin
            if (bytes_due.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%t: result beat %02h with no pop outstanding", $realtime,
                           rsp_tdata);
            end else begin
               due = bytes_due.pop_front();
               if (rsp_tdata !== due) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("%t: read_data expected %02h got %02h", $realtime, due,
                              rsp_tdata);
               end
            end
         end

         if (req_tvalid && req_tready) begin
            if (req_tuser[0]) begin
               // pop: hand out the slot, zero it, advance
               bytes_due.push_back(ring_copy[rd_ptr]);
               ring_copy[rd_ptr] = 8'h00;
               rd_ptr = (rd_ptr + 1 == RING_DEPTH) ? 0 : rd_ptr + 1;
            end else begin
               mix_sum = {1'b0, req_tdata[7:0]} + {1'b0, req_tdata[15:8]};
               sample  = cfg.pokey_enable ? mix_sum[8:1] : req_tdata[7:0];
               if (req_tuser[1]) begin
                  rate_acc        = 18'(cfg.out_rate);
                  copies_in_frame = '0;
               end else if (copies_in_frame < cfg.frame_len) begin
                  // accumulator holds once the frame quota is met
                  rate_acc = rate_acc + 18'(cfg.out_rate);
               end
               while (rate_acc >= armr_pkg::SRC_RATE &&
                      copies_in_frame < cfg.frame_len) begin
                  ring_copy[wr_ptr] = sample;
                  wr_ptr = (wr_ptr + 1 == RING_DEPTH) ? 0 : wr_ptr + 1;
                  rate_acc        = rate_acc - armr_pkg::SRC_RATE;
                  copies_in_frame = copies_in_frame + 12'd1;
               end
            end
         end
      end
      mismatches    <= errors;
      bytes_pending <= bytes_due.size();
   end

endmodule

### tb/audio_resample_mix_ring_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_resample_mix_ring_tb: regression of the resampling byte ring
// Drives source-sample and pop beats with random gaps and result stalls,
// reprograms the registers between phases while the block is idle, and
// leaves prediction and comparison to ring_byte_checker. A small ring is
// built so that pointer wrap and overrun happen many times in one run.
// ----------------------------------------------------------------------------
module audio_resample_mix_ring_tb;

   // small ring: short clearing sweep, frequent wrap and overwrite
   localparam int unsigned RING_DEPTH      = 256;
   // margin for queued source beats to finish their copies; two can sit queued
   localparam int unsigned SETTLE_CYCLES   = 64;
   // clearing sweep plus longest gap, stall and settle, with ample margin
   localparam int unsigned STALL_LIMIT     = 4000;
   localparam int unsigned RANDOM_PHASES   = 8;
   localparam int unsigned BEATS_PER_PHASE = 78;
   // no register answers to this index; writes to it must change nothing
   localparam logic [1:0]  CSR_UNMAPPED    = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [7:0] tia_sample, [15:8] pokey_sample
   logic [1:0]  req_tuser;   // [0] req_type, [1] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] read_data
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [16:0] csr_data;

   int          ring_mismatches;
   int          ring_pending;
   logic        quiet_phase;

   audio_resample_mix_ring #(.RING_DEPTH(RING_DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   ring_byte_checker #(.RING_DEPTH(RING_DEPTH)) ring_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .mismatches    (ring_mismatches),
      .bytes_pending (ring_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle length for either side: mostly none or short, now and then long.
   // A quiet phase runs back to back.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (quiet_phase) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Sample bytes lean toward the ends of the range.
   function automatic logic [7:0] pick_byte();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 8'h00;
      if (roll == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   // Present one request beat after an optional gap; return on the edge that
   // takes it. Ready is looked at mid-cycle, where it is settled.
   task automatic push_req(input logic rd, input logic fs, input logic [7:0] tia,
                           input logic [7:0] pokey);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pokey, tia};
      req_tuser  <= {fs, rd};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
   endtask

   // Write one register; valid stays high so writes can go back to back.
   task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
   endtask

   // Drop valid, wait for every popped byte to come back, then let any source
   // beat still in the queue finish its copies.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (ring_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side: ready-high stretches broken by stalls of random length.
   initial begin
      int unsigned gap;
      rsp_tready <= 1'b1;
      forever begin
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 200)) @(posedge clock);
         else repeat ($urandom_range(1, 12)) @(posedge clock);
         gap = pick_gap();
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: count cycles in which no channel moves a beat.
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(negedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("audio_resample_mix_ring regression: fail");
      $finish;
   end

   initial begin
      int unsigned phase;
      int unsigned beat;
      int unsigned frame_left;
      logic        fs;
      logic [16:0] rate;
      logic [11:0] quota;

      quiet_phase = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= armr_pkg::CSR_OUT_RATE;
      csr_data   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // No frame start since reset: accumulator counts up from zero at the
      // reset rate. Third pop reaches a slot never written and must read zero.
      push_req(1'b0, 1'b0, 8'hFF, 8'h00);
      push_req(1'b0, 1'b0, 8'h00, 8'hFF);
      push_req(1'b1, 1'b0, 8'h00, 8'h00);
      push_req(1'b1, 1'b1, 8'hFF, 8'hFF);
      push_req(1'b1, 1'b0, 8'h00, 8'h00);

      // Fastest rate, quota of two, POKEY mixing: the full-scale pair checks
      // the 9-bit sum, the second sample lands after the quota is met.
      settle();
      write_reg(armr_pkg::CSR_POKEY_ENABLE, 17'd1);
      write_reg(armr_pkg::CSR_FRAME_LEN, 17'd2);
      write_reg(armr_pkg::CSR_OUT_RATE, 17'd96000);
      csr_valid <= 1'b0;
      push_req(1'b0, 1'b1, 8'hFF, 8'hFF);
      push_req(1'b0, 1'b0, 8'hFF, 8'h01);
      push_req(1'b1, 1'b0, 8'h00, 8'h00);
      push_req(1'b1, 1'b0, 8'h00, 8'h00);
      push_req(1'b1, 1'b0, 8'h00, 8'h00);
      push_req(1'b0, 1'b1, 8'h00, 8'h00);
      push_req(1'b1, 1'b0, 8'h00, 8'h00);
      push_req(1'b1, 1'b0, 8'h00, 8'h00);

      // Zero rate writes nothing; the unmapped index is ignored and the
      // frame length keeps only its low twelve bits.
      settle();
      write_reg(armr_pkg::CSR_OUT_RATE, 17'd0);
      write_reg(CSR_UNMAPPED, 17'h1FFFF);
      write_reg(armr_pkg::CSR_FRAME_LEN, 17'h1F005);
      csr_valid <= 1'b0;
      push_req(1'b0, 1'b1, 8'h55, 8'hAA);
      push_req(1'b0, 1'b0, 8'hAA, 8'h55);
      push_req(1'b1, 1'b0, 8'h00, 8'h00);

      // Slowest rate with an empty quota, then the quota raised mid-frame.
      settle();
      write_reg(armr_pkg::CSR_OUT_RATE, 17'd8000);
      write_reg(armr_pkg::CSR_FRAME_LEN, 17'd0);
      csr_valid <= 1'b0;
      push_req(1'b0, 1'b1, 8'h12, 8'h34);
      settle();
      write_reg(armr_pkg::CSR_FRAME_LEN, 17'd2048);
      csr_valid <= 1'b0;
      push_req(1'b0, 1'b0, 8'hAA, 8'h55);
      push_req(1'b0, 1'b0, 8'hAA, 8'h55);
      push_req(1'b0, 1'b0, 8'h55, 8'hAA);
      push_req(1'b0, 1'b0, 8'hAA, 8'h55);
      push_req(1'b1, 1'b0, 8'h00, 8'h00);
      push_req(1'b1, 1'b0, 8'h00, 8'h00);

      // Random phases: frames of random length with pops mixed in; a few
      // frame marks are flipped to break the framing.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         case ($urandom_range(0, 9))
            0:       rate = 17'd8000;
            1:       rate = 17'd96000;
            2:       rate = 17'd0;
            3:       rate = 17'd44100;
            default: rate = 17'($urandom_range(8000, 96000));
         endcase
         case ($urandom_range(0, 9))
            0:       quota = 12'd0;
            1:       quota = 12'd2048;
            2:       quota = 12'd1;
            3, 4, 5: quota = 12'($urandom_range(1, 16));
            default: quota = 12'($urandom_range(0, 2048));
         endcase
         write_reg(armr_pkg::CSR_OUT_RATE, rate);
         write_reg(armr_pkg::CSR_FRAME_LEN, {5'd0, quota});
         write_reg(armr_pkg::CSR_POKEY_ENABLE, 17'($urandom_range(0, 1)));
         csr_valid <= 1'b0;
         quiet_phase = ($urandom_range(0, 3) == 0);
         frame_left = 0;
         for (beat = 0; beat < BEATS_PER_PHASE; beat++) begin
            if ($urandom_range(0, 99) < 45) begin
               push_req(1'b1, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
            end else begin
               fs = (frame_left == 0);
               if ($urandom_range(0, 19) == 0) fs = ~fs;
               if (fs) frame_left = $urandom_range(0, 19);
               else if (frame_left != 0) frame_left--;
               push_req(1'b0, fs, pick_byte(), pick_byte());
            end
         end
      end

      // Hold until every byte is back and the back end has gone quiet.
      quiet_phase = 1'b0;
      settle();
      if (ring_mismatches == 0 && ring_pending == 0)
         $display("audio_resample_mix_ring regression: pass");
      else
         $display("audio_resample_mix_ring regression: fail");
      $finish;
   end

endmodule

### files.f
src/armr_pkg.sv
src/armr_ram.sv
src/armr_front.sv
src/armr_queue.sv
src/armr_back.sv
src/audio_resample_mix_ring.sv
tb/ring_byte_checker.sv
tb/audio_resample_mix_ring_tb.sv
